>>> hw/rtl/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgW  = 16;
	localparam int unsigned ModeW = 3;
	localparam int unsigned IdxW  = 2;

	localparam logic [ModeW-1:0] MODE_IDLE    = 3'd0;
	localparam logic [ModeW-1:0] MODE_PDEB    = 3'd1;
	localparam logic [ModeW-1:0] MODE_PRESSED = 3'd2;
	localparam logic [ModeW-1:0] MODE_RDEB    = 3'd3;
	localparam logic [ModeW-1:0] MODE_WREL    = 3'd4;
	localparam logic [ModeW-1:0] MODE_WSECOND = 3'd5;

	localparam logic [IdxW-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [IdxW-1:0] REG_HOLD     = 2'd1;
	localparam logic [IdxW-1:0] REG_WINDOW   = 2'd2;

	localparam logic [CfgW-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CfgW-1:0] HOLD_RST     = 16'd1000;
	localparam logic [CfgW-1:0] WINDOW_RST   = 16'd300;

	typedef struct packed {
		logic [CfgW-1:0] debounce_ms;
		logic [CfgW-1:0] hold_ms;
		logic [CfgW-1:0] double_window_ms;
	} cfg_t;

	typedef struct packed {
		logic [TimeW-1:0] now_ms;
		logic             edge_seen;
		logic             pressed_level;
		logic             take_single;
		logic             take_double;
		logic             take_held;
		logic             restart;
	} item_t;

	typedef struct packed {
		logic             single_event;
		logic             double_event;
		logic             hold_event;
		logic [ModeW-1:0] mode;
	} result_t;

	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic [TimeW-1:0] mark_time;
		logic             single_flag;
		logic             double_flag;
		logic             hold_flag;
		logic             second_pending;
		logic             completing_double;
		logic             hold_fired;
	} state_t;

endpackage
`default_nettype wire

>>> hw/rtl/button_press_classifier_top.sv
// An accepted request is captured in the input register, and its result then in the output register.
// Throughput: one request per cycle while the output is not stalled; the classification step is
// one pass of compares and muxes between the input register and the state and result registers.
// Reset (arst_n low, asynchronous): mode idle, all flags and the time mark clear,
// configuration back to debounce 50, hold 1000, double window 300.
`default_nettype none
module button_press_classifier_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [bpc_pkg::TimeW-1:0]          now_ms,
	input  wire logic                               edge_seen,
	input  wire logic                               pressed_level,
	input  wire logic                               take_single,
	input  wire logic                               take_double,
	input  wire logic                               take_held,
	input  wire logic                               restart,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    single_event,
	output logic                                    double_event,
	output logic                                    hold_event,
	output logic [bpc_pkg::ModeW-1:0]               mode,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [bpc_pkg::IdxW-1:0]           cfg_index,
	input  wire logic [bpc_pkg::CfgW-1:0]           cfg_data
);

	bpc_pkg::cfg_t    cfg;
	bpc_pkg::item_t   item_s1;
	logic             valid_s1;
	bpc_pkg::state_t  state_q;
	bpc_pkg::state_t  state_nxt;
	bpc_pkg::result_t res;
	bpc_pkg::result_t res_s2;
	logic             valid_s2;
	logic             adv;
	logic             accept;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpc_step u_step (
		.cfg  (cfg),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.now_ms        <= now_ms;
			item_s1.edge_seen     <= edge_seen;
			item_s1.pressed_level <= pressed_level;
			item_s1.take_single   <= take_single;
			item_s1.take_double   <= take_double;
			item_s1.take_held     <= take_held;
			item_s1.restart       <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			state_q.mode <= bpc_pkg::MODE_IDLE;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign single_event = res_s2.single_event;
	assign double_event = res_s2.double_event;
	assign hold_event   = res_s2.hold_event;
	assign mode         = res_s2.mode;

endmodule
`default_nettype wire

>>> hw/rtl/bpc_cfg.sv
`default_nettype none
module bpc_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [bpc_pkg::IdxW-1:0]  cfg_index,
	input  wire logic [bpc_pkg::CfgW-1:0]  cfg_data,
	output bpc_pkg::cfg_t                  cfg
);

	bpc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms      <= bpc_pkg::DEBOUNCE_RST;
			cfg_q.hold_ms          <= bpc_pkg::HOLD_RST;
			cfg_q.double_window_ms <= bpc_pkg::WINDOW_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bpc_pkg::REG_DEBOUNCE: cfg_q.debounce_ms      <= cfg_data;
				bpc_pkg::REG_HOLD:     cfg_q.hold_ms          <= cfg_data;
				bpc_pkg::REG_WINDOW:   cfg_q.double_window_ms <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/bpc_step.sv
`default_nettype none
module bpc_step (
	input  wire bpc_pkg::cfg_t    cfg,
	input  wire bpc_pkg::item_t   item,
	input  wire bpc_pkg::state_t  cur,
	output bpc_pkg::state_t       nxt,
	output bpc_pkg::result_t      res
);

	logic [bpc_pkg::TimeW-1:0] d0;
	logic [bpc_pkg::TimeW-1:0] deb_w;
	logic [bpc_pkg::TimeW-1:0] hold_w;
	logic [bpc_pkg::TimeW-1:0] win_w;

	assign d0     = item.now_ms - cur.mark_time;
	assign deb_w  = {{(bpc_pkg::TimeW-bpc_pkg::CfgW){1'b0}}, cfg.debounce_ms};
	assign hold_w = {{(bpc_pkg::TimeW-bpc_pkg::CfgW){1'b0}}, cfg.hold_ms};
	assign win_w  = {{(bpc_pkg::TimeW-bpc_pkg::CfgW){1'b0}}, cfg.double_window_ms};

	always_comb begin
		bpc_pkg::state_t           st;
		logic                      mnow;
		logic [bpc_pkg::TimeW-1:0] el;
		st   = cur;
		mnow = 1'b0;
		el   = d0;
		res  = '0;
		if (item.restart) begin
			st      = '0;
			st.mode = bpc_pkg::MODE_IDLE;
			res     = '0;
			res.mode = bpc_pkg::MODE_IDLE;
		end else begin
			if (item.edge_seen || item.pressed_level) begin
				if (st.mode == bpc_pkg::MODE_IDLE) begin
					st.mode = bpc_pkg::MODE_PDEB;
					mnow    = 1'b1;
				end else if (st.mode == bpc_pkg::MODE_WSECOND) begin
					if (d0 <= win_w) begin
						st.completing_double = 1'b1;
					end else begin
						st.single_flag       = 1'b1;
						st.completing_double = 1'b0;
					end
					st.mode = bpc_pkg::MODE_PDEB;
					mnow    = 1'b1;
				end
			end

			el = mnow ? '0 : d0;
			if (st.mode == bpc_pkg::MODE_PDEB && el >= deb_w) begin
				if (st.completing_double) begin
					st.double_flag       = 1'b1;
					st.second_pending    = 1'b1;
					st.completing_double = 1'b0;
				end
				st.mode       = bpc_pkg::MODE_PRESSED;
				st.hold_fired = 1'b0;
				if (item.pressed_level) begin
					mnow = 1'b1;
				end else if (st.second_pending) begin
					st.second_pending = 1'b0;
					st.mode           = bpc_pkg::MODE_IDLE;
				end else begin
					st.mode = bpc_pkg::MODE_WSECOND;
					mnow    = 1'b1;
				end
			end

			el = mnow ? '0 : d0;
			if (st.mode == bpc_pkg::MODE_PRESSED) begin
				if (!st.hold_fired && el >= hold_w) begin
					st.hold_flag  = 1'b1;
					st.hold_fired = 1'b1;
					st.mode       = bpc_pkg::MODE_WREL;
				end else if (!item.pressed_level) begin
					st.mode = bpc_pkg::MODE_RDEB;
					mnow    = 1'b1;
				end
			end

			el = mnow ? '0 : d0;
			if (st.mode == bpc_pkg::MODE_RDEB) begin
				if (item.pressed_level) begin
					st.mode = bpc_pkg::MODE_PRESSED;
				end else if (el >= deb_w) begin
					if (st.hold_fired) begin
						st.mode = bpc_pkg::MODE_IDLE;
					end else if (st.second_pending) begin
						st.second_pending = 1'b0;
						st.mode           = bpc_pkg::MODE_IDLE;
					end else begin
						st.mode = bpc_pkg::MODE_WSECOND;
						mnow    = 1'b1;
					end
				end
			end

			if (st.mode == bpc_pkg::MODE_WREL && !item.pressed_level) begin
				st.mode = bpc_pkg::MODE_IDLE;
			end

			el = mnow ? '0 : d0;
			if (st.mode == bpc_pkg::MODE_WSECOND && el > win_w) begin
				st.single_flag       = 1'b1;
				st.completing_double = 1'b0;
				st.mode              = bpc_pkg::MODE_IDLE;
			end

			res.single_event = st.single_flag;
			res.double_event = st.double_flag;
			res.hold_event   = st.hold_flag;
			res.mode         = st.mode;

			if (item.take_single) begin
				st.single_flag = 1'b0;
			end
			if (item.take_double && st.double_flag) begin
				st.double_flag = 1'b0;
				st.single_flag = 1'b0;
			end
			if (item.take_held) begin
				st.hold_flag = 1'b0;
			end
			st.mark_time = mnow ? item.now_ms : cur.mark_time;
		end
		nxt = st;
	end

endmodule
`default_nettype wire

>>> hw/rtl/bpc_checker.sv
`default_nettype none
module bpc_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_stall,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic                      single_event,
	input wire logic                      double_event,
	input wire logic                      hold_event,
	input wire logic [bpc_pkg::ModeW-1:0] mode
);

	ap_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mode <= bpc_pkg::MODE_WSECOND))
		else $error("mode out of range");

	ap_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(mode)
			&& $stable(single_event) && $stable(double_event) && $stable(hold_event)))
		else $error("stalled result changed");

	ap_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a request two cycles earlier");

endmodule

bind button_press_classifier_top bpc_checker u_bpc_checker (.*);
`default_nettype wire
